// ----- src/rsig_pkg.sv -----
package rsig_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_TARGETS  = 64;
    localparam int DEF_SCOPE_CENTER = 512;

    // Field and datapath widths
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int LEVEL_W    = 10;
    localparam int RADIUS_W   = 32;
    localparam int SLOT_W     = 6;
    localparam int COORD_W    = 16;               // Q12.4 target offset
    localparam int POS_W      = 10;               // trace position and beam codes
    localparam int DIFF_W     = POS_W + 1;        // signed difference of two codes
    localparam int FRAC_W     = 4;                // Q.4 fraction bits
    localparam int BEAM_OFS_W = DIFF_W + FRAC_W;  // beam offset in Q11.4
    localparam int SUM_W      = COORD_W + 1;      // beam offset plus target offset
    localparam int MAG_W      = SUM_W - 1;        // magnitude always fits here
    localparam int SQ_W       = 2 * MAG_W;
    localparam int DIST_W     = SQ_W + 1;
    localparam int WORD_W     = 16;

    // Point classification constants
    localparam logic [DIFF_W-1:0]        TRACE_OFFSET   = DIFF_W'(512);
    localparam logic signed [DIFF_W-1:0] TRACE_MIN_EXCL = DIFF_W'(2);
    localparam logic [POS_W-1:0]         TICK_MASK      = POS_W'(16'h003F);
    localparam logic [WORD_W-1:0]        LEVEL_MASK     = 16'h0FFF;
    localparam logic [WORD_W-1:0]        WORD_PREFIX    = 16'hF000;

    // Item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_SWEEP = 1'b1;

    // Register map, word index
    typedef enum logic [2:0] {
        REG_SCALE  = 3'd0,
        REG_DIM    = 3'd1,
        REG_BLANK  = 3'd2,
        REG_BLIP   = 3'd3,
        REG_RADIUS = 3'd4
    } cfg_reg_t;

    localparam logic [LEVEL_W-1:0]  RST_SCALE  = 10'd470;
    localparam logic [LEVEL_W-1:0]  RST_DIM    = 10'd512;
    localparam logic [LEVEL_W-1:0]  RST_BLANK  = 10'd1023;
    localparam logic [LEVEL_W-1:0]  RST_BLIP   = 10'd0;
    localparam logic [RADIUS_W-1:0] RST_RADIUS = 32'd5138;

    typedef struct packed {
        logic [LEVEL_W-1:0]  scale_intensity;
        logic [LEVEL_W-1:0]  dim_intensity;
        logic [LEVEL_W-1:0]  blank_intensity;
        logic [LEVEL_W-1:0]  blip_intensity;
        logic [RADIUS_W-1:0] blip_radius_sq;
    } cfg_t;

    // One target table entry
    typedef struct packed {
        logic                      active;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } target_entry_t;

    // Status from the distance unit back to the sequencer
    typedef struct packed {
        logic pipe_busy;
        logic hit_vld;
        logic hit;
    } dist_status_t;

    // Intensity level to DAC command word
    function automatic logic [WORD_W-1:0] dac_word_of(input logic [LEVEL_W-1:0] level);
        return ((WORD_W'(level) << 2) & LEVEL_MASK) | WORD_PREFIX;
    endfunction

endpackage

// ----- src/rsig_cfg_regs.sv -----
module rsig_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rsig_pkg::ADDR_W-1:0]   paddr,
    input  logic [rsig_pkg::DATA_W-1:0]   pwdata,
    output logic [rsig_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output rsig_pkg::cfg_t                cfg
);
    import rsig_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    cfg_reg_t reg_idx;
    logic     wr_beat;

    assign reg_idx = cfg_reg_t'(paddr[ADDR_W-1:2]);
    assign wr_beat = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_beat)
        begin
            unique case (reg_idx)
                REG_SCALE:  cfg_next.scale_intensity = pwdata[LEVEL_W-1:0];
                REG_DIM:    cfg_next.dim_intensity   = pwdata[LEVEL_W-1:0];
                REG_BLANK:  cfg_next.blank_intensity = pwdata[LEVEL_W-1:0];
                REG_BLIP:   cfg_next.blip_intensity  = pwdata[LEVEL_W-1:0];
                REG_RADIUS: cfg_next.blip_radius_sq  = pwdata[RADIUS_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_intensity <= RST_SCALE;
            cfg_reg.dim_intensity   <= RST_DIM;
            cfg_reg.blank_intensity <= RST_BLANK;
            cfg_reg.blip_intensity  <= RST_BLIP;
            cfg_reg.blip_radius_sq  <= RST_RADIUS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back mux
    always_comb
    begin
        unique case (reg_idx)
            REG_SCALE:  prdata = DATA_W'(cfg_reg.scale_intensity);
            REG_DIM:    prdata = DATA_W'(cfg_reg.dim_intensity);
            REG_BLANK:  prdata = DATA_W'(cfg_reg.blank_intensity);
            REG_BLIP:   prdata = DATA_W'(cfg_reg.blip_intensity);
            REG_RADIUS: prdata = DATA_W'(cfg_reg.blip_radius_sq);
            default:    prdata = '0;
        endcase
    end

endmodule

// ----- src/rsig_target_mem.sv -----
module rsig_target_mem #(
    parameter int DEPTH = rsig_pkg::DEF_MAX_TARGETS,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [IDX_W-1:0]        wr_idx,
    input  rsig_pkg::target_entry_t wr_data,
    input  logic                    rd_en,
    input  logic [IDX_W-1:0]        rd_idx,
    output rsig_pkg::target_entry_t rd_data
);
    import rsig_pkg::*;

    target_entry_t mem [DEPTH];
    target_entry_t rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/rsig_dist_unit.sv -----
module rsig_dist_unit (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_vld,
    input  logic signed [rsig_pkg::BEAM_OFS_W-1:0]   beam_dx,
    input  logic signed [rsig_pkg::BEAM_OFS_W-1:0]   beam_dy,
    input  rsig_pkg::target_entry_t                  entry,
    input  logic [rsig_pkg::RADIUS_W-1:0]            radius_sq,
    output rsig_pkg::dist_status_t                   status
);
    import rsig_pkg::*;

    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [MAG_W-1:0]        mag_x_next;
    logic [MAG_W-1:0]        mag_y_next;
    logic [DIST_W-1:0]       dist_next;

    logic              a_vld_reg;
    logic [MAG_W-1:0]  a_mag_x_reg;
    logic [MAG_W-1:0]  a_mag_y_reg;
    logic              b_vld_reg;
    logic [SQ_W-1:0]   b_sq_x_reg;
    logic [SQ_W-1:0]   b_sq_y_reg;
    logic              c_vld_reg;
    logic              c_hit_reg;

    // Stage A: offsets and magnitudes
    assign sum_x      = SUM_W'(beam_dx) + SUM_W'(entry.x);
    assign sum_y      = SUM_W'(beam_dy) - SUM_W'(entry.y);
    assign mag_x_next = sum_x[SUM_W-1] ? MAG_W'(-sum_x) : MAG_W'(sum_x);
    assign mag_y_next = sum_y[SUM_W-1] ? MAG_W'(-sum_y) : MAG_W'(sum_y);

    // Stage C: squared distance against the radius
    assign dist_next = DIST_W'(b_sq_x_reg) + DIST_W'(b_sq_y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= in_vld && entry.active;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        a_mag_x_reg <= mag_x_next;
        a_mag_y_reg <= mag_y_next;
        b_sq_x_reg  <= SQ_W'(a_mag_x_reg) * SQ_W'(a_mag_x_reg);
        b_sq_y_reg  <= SQ_W'(a_mag_y_reg) * SQ_W'(a_mag_y_reg);
        c_hit_reg   <= dist_next < DIST_W'(radius_sq);
    end

    assign status.pipe_busy = a_vld_reg || b_vld_reg || c_vld_reg;
    assign status.hit_vld   = c_vld_reg;
    assign status.hit       = c_hit_reg;

endmodule

// ----- src/radar_scope_intensity_gen_core.sv -----
// A load beat writes its table slot, busy stays low; a blanked sweep point gives its result
// in the cycle after it is taken. Any other point scans all MAX_TARGETS slots, one a cycle,
// through the shared distance pipeline; result and busy drop come together once the pipeline
// holds no active slot, so later when the last slots are active.
// Throughput: loads and blanked points one a cycle while idle; a scanned point holds busy.
// Reset: control and cfg registers to reset values, busy high clearing the table; no stall.
module radar_scope_intensity_gen_core #(
    parameter int MAX_TARGETS  = rsig_pkg::DEF_MAX_TARGETS,
    parameter int SCOPE_CENTER = rsig_pkg::DEF_SCOPE_CENTER
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 kind,
    input  logic [rsig_pkg::SLOT_W-1:0]          target_slot,
    input  logic                                 target_active,
    input  logic signed [rsig_pkg::COORD_W-1:0]  target_x,
    input  logic signed [rsig_pkg::COORD_W-1:0]  target_y,
    input  logic [rsig_pkg::POS_W-1:0]           trace_pos,
    input  logic [rsig_pkg::POS_W-1:0]           beam_x,
    input  logic [rsig_pkg::POS_W-1:0]           beam_y,
    output logic                                 done,
    output logic [rsig_pkg::WORD_W-1:0]          dac_word,
    output logic                                 blip_hit,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rsig_pkg::ADDR_W-1:0]          paddr,
    input  logic [rsig_pkg::DATA_W-1:0]          pwdata,
    output logic [rsig_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);
    import rsig_pkg::*;

    localparam int IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(MAX_TARGETS - 1);
    localparam logic [DIFF_W-1:0] CENTER_C = DIFF_W'(SCOPE_CENTER);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DRAIN = 4'b1000
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [IDX_W-1:0]         idx_reg;
    logic [IDX_W-1:0]         idx_next;
    logic                     rd_vld_reg;
    logic                     rd_vld_next;
    logic                     hit_acc_reg;
    logic                     hit_acc_next;
    logic                     done_reg;
    logic                     done_next;
    logic signed [BEAM_OFS_W-1:0] dx_reg;
    logic signed [BEAM_OFS_W-1:0] dx_next;
    logic signed [BEAM_OFS_W-1:0] dy_reg;
    logic signed [BEAM_OFS_W-1:0] dy_next;
    logic                     tick_reg;
    logic                     tick_next;
    logic [WORD_W-1:0]        dac_word_reg;
    logic [WORD_W-1:0]        dac_word_next;
    logic                     blip_hit_reg;
    logic                     blip_hit_next;

    logic                     accept;
    logic signed [DIFF_W-1:0] r_pos;
    logic                     blanked;
    logic                     slot_ok;
    logic                     scan_hit;
    logic [LEVEL_W-1:0]       trace_level;

    cfg_t                     cfg;
    dist_status_t             dist_st;
    logic                     mem_wr_en;
    logic [IDX_W-1:0]         mem_wr_idx;
    target_entry_t            mem_wr_data;
    logic                     mem_rd_en;
    target_entry_t            mem_rd_data;

    // Configuration registers
    rsig_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Target table
    rsig_target_mem #(
        .DEPTH (MAX_TARGETS),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_idx  (mem_wr_idx),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_idx  (idx_reg),
        .rd_data (mem_rd_data)
    );

    // Shared distance pipeline
    rsig_dist_unit u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vld    (rd_vld_reg),
        .beam_dx   (dx_reg),
        .beam_dy   (dy_reg),
        .entry     (mem_rd_data),
        .radius_sq (cfg.blip_radius_sq),
        .status    (dist_st)
    );

    // Point classification
    assign accept   = start && !busy;
    assign r_pos    = signed'({1'b0, trace_pos} - TRACE_OFFSET);
    assign blanked  = r_pos <= TRACE_MIN_EXCL;
    assign slot_ok  = 32'(target_slot) < 32'(MAX_TARGETS);
    assign scan_hit = hit_acc_reg || (dist_st.hit_vld && dist_st.hit);
    assign trace_level = tick_reg ? cfg.scale_intensity : cfg.dim_intensity;

    // Table write port: clearing sweep or load beat
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_idx  = idx_reg;
        mem_wr_data = '0;
        if (state_reg == S_CLEAR)
        begin
            mem_wr_en = 1'b1;
        end
        else if (accept && kind == KIND_LOAD && slot_ok)
        begin
            mem_wr_en          = 1'b1;
            mem_wr_idx         = IDX_W'(target_slot);
            mem_wr_data.active = target_active;
            mem_wr_data.x      = target_x;
            mem_wr_data.y      = target_y;
        end
    end

    assign mem_rd_en = state_reg == S_SCAN;

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        rd_vld_next   = state_reg == S_SCAN;
        hit_acc_next  = hit_acc_reg;
        done_next     = 1'b0;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        tick_next     = tick_reg;
        dac_word_next = dac_word_reg;
        blip_hit_next = blip_hit_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept && kind == KIND_SWEEP)
                begin
                    dx_next      = {signed'({1'b0, beam_x} - CENTER_C), FRAC_W'(0)};
                    dy_next      = {signed'({1'b0, beam_y} - CENTER_C), FRAC_W'(0)};
                    tick_next    = (r_pos[POS_W-1:0] & TICK_MASK) == '0;
                    hit_acc_next = 1'b0;
                    idx_next     = '0;
                    if (blanked)
                    begin
                        done_next     = 1'b1;
                        dac_word_next = dac_word_of(cfg.blank_intensity);
                        blip_hit_next = 1'b0;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                hit_acc_next = scan_hit;
                idx_next     = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                hit_acc_next = scan_hit;
                if (!rd_vld_reg && !dist_st.pipe_busy)
                begin
                    state_next    = S_IDLE;
                    done_next     = 1'b1;
                    blip_hit_next = hit_acc_reg;
                    dac_word_next = dac_word_of(hit_acc_reg ? cfg.blip_intensity
                                                            : trace_level);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            idx_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            hit_acc_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            rd_vld_reg  <= rd_vld_next;
            hit_acc_reg <= hit_acc_next;
            done_reg    <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        tick_reg     <= tick_next;
        dac_word_reg <= dac_word_next;
        blip_hit_reg <= blip_hit_next;
    end

    assign busy     = state_reg != S_IDLE;
    assign done     = done_reg;
    assign dac_word = dac_word_reg;
    assign blip_hit = blip_hit_reg;

    // A load beat never produces a result
    a_load_no_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_LOAD) |=> !done
    ) else $error("result strobe after a load beat");

    // A blanked point answers in the next cycle, without a blip
    a_blank_fast: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_SWEEP && blanked) |=> (done && !blip_hit)
    ) else $error("blanked point not answered in one cycle");

    // The result strobe only comes while the block is idle
    a_done_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> !busy
    ) else $error("result strobe while busy");

endmodule
